// ===== rtl/ccrc_pkg.sv =====
// Shared constants, register codes and the byte update function of the CRC engine.
package ccrc_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 3;

    // width select codes
    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_WIDTH_SELECT  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_POLYNOMIAL    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_INITIAL_VALUE = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REFLECTED     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_FINAL_XOR     = 3'd4;

    // reset values
    localparam logic [1:0]       RST_WIDTH_SELECT  = WSEL_16;
    localparam logic [CRC_W-1:0] RST_POLYNOMIAL    = 32'h0000_8005;
    localparam logic [CRC_W-1:0] RST_INITIAL_VALUE = 32'h0000_FFFF;
    localparam logic             RST_REFLECTED     = 1'b1;
    localparam logic [CRC_W-1:0] RST_FINAL_XOR     = 32'h0000_0000;

    typedef logic [CRC_W-1:0] t_crc;

    // unused code 3 behaves as 32 bits
    function automatic t_crc crc_mask(input logic [1:0] wsel);
        t_crc m;
        begin
            case (wsel)
                WSEL_8:  m = 32'h0000_00FF;
                WSEL_16: m = 32'h0000_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // absorb one byte: eight shift steps unrolled into an XOR network
    function automatic t_crc crc_byte(input t_crc crc_in, input logic [BYTE_W-1:0] data,
                                      input t_crc poly, input logic [1:0] wsel,
                                      input logic refl);
        t_crc m;
        t_crc p;
        t_crc rev;
        t_crc rp;
        t_crc c;
        logic fb;
        begin
            m = crc_mask(wsel);
            p = poly & m;
            for (int i = 0; i < CRC_W; i++) begin
                rev[i] = p[CRC_W-1-i];
            end
            case (wsel)
                WSEL_8:  rp = rev >> 24;
                WSEL_16: rp = rev >> 16;
                default: rp = rev;
            endcase
            c = crc_in & m;
            if (refl) begin
                c = c ^ {24'h0, data};
            end else begin
                case (wsel)
                    WSEL_8:  c = c ^ {24'h0, data};
                    WSEL_16: c = c ^ {16'h0, data, 8'h0};
                    default: c = c ^ {data, 24'h0};
                endcase
            end
            for (int i = 0; i < BYTE_W; i++) begin
                if (refl) begin
                    fb = c[0];
                    c  = (c >> 1) ^ (fb ? rp : '0);
                end else begin
                    case (wsel)
                        WSEL_8:  fb = c[7];
                        WSEL_16: fb = c[15];
                        default: fb = c[31];
                    endcase
                    c = ((c << 1) ^ (fb ? p : '0)) & m;
                end
            end
            return c & m;
        end
    endfunction

endpackage

// ===== rtl/configurable_crc_engine_core.sv =====
// Byte-serial configurable CRC engine: config registers, CRC register, result skid.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_data_byte, i_first_byte, i_last_byte
//  out     | source    | o_out_valid / i_out_stall | o_crc_value
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One byte per cycle: the byte update is one XOR network from the CRC register back to itself.
//  A last byte's result is registered in the output register, or in the skid entry while held.
//  Output register plus one skid entry; input stalls only while the skid entry is full.
//  Reset (synchronous) restores config defaults and loads the CRC register with 0xFFFF.
//  Config writes are always ready.
module configurable_crc_engine_core
    import ccrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CRC_W-1:0]  o_crc_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CRC_W-1:0]  i_cfg_data
);

    logic [1:0] r_width_select;
    t_crc       r_polynomial;
    t_crc       r_initial_value;
    logic       r_reflected;
    t_crc       r_final_xor;
    t_crc       r_crc;
    logic       r_out_valid;
    t_crc       r_out_crc;
    logic       r_skid_valid;
    t_crc       r_skid_crc;

    logic       in_xfer;
    logic       out_xfer;
    logic       push;
    t_crc       mask;
    t_crc       crc_start;
    t_crc       n_crc;
    t_crc       result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

    assign in_xfer  = i_in_valid && !r_skid_valid;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign push     = in_xfer && i_last_byte;

    assign mask      = crc_mask(r_width_select);
    assign crc_start = i_first_byte ? r_initial_value : r_crc;
    assign n_crc     = crc_byte(crc_start, i_data_byte, r_polynomial, r_width_select,
                                r_reflected);
    assign result    = (n_crc ^ r_final_xor) & mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_select  <= RST_WIDTH_SELECT;
            r_polynomial    <= RST_POLYNOMIAL;
            r_initial_value <= RST_INITIAL_VALUE;
            r_reflected     <= RST_REFLECTED;
            r_final_xor     <= RST_FINAL_XOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH_SELECT:  r_width_select  <= i_cfg_data[1:0];
                CFG_POLYNOMIAL:    r_polynomial    <= i_cfg_data;
                CFG_INITIAL_VALUE: r_initial_value <= i_cfg_data;
                CFG_REFLECTED:     r_reflected     <= i_cfg_data[0];
                CFG_FINAL_XOR:     r_final_xor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= RST_INITIAL_VALUE;
        end else if (in_xfer) begin
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_crc <= r_skid_crc;
            end else if (push) begin
                r_out_crc <= result;
            end
        end else if (push) begin
            r_skid_crc <= result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !r_out_valid) |=> r_out_valid)
        else $error("last byte transfer did not produce a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_last_byte && !r_out_valid && !r_skid_valid) |=> !r_out_valid)
        else $error("result produced without a last byte");

    a_narrow_crc_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_width_select == WSEL_8) |=> (r_crc[CRC_W-1:8] == '0))
        else $error("8-bit CRC register has upper bits set");

    a_result_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_width_select == WSEL_16 && !r_out_valid)
            |=> (r_out_crc[CRC_W-1:16] == '0))
        else $error("16-bit result has upper bits set");

endmodule
